FILE: rtl/core/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and defaults for the mixed-radix odometer counter.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MAX_DIGITS_DEF = 8;
    localparam int DIGIT_BITS_DEF = 4;

    localparam int FIELD_W = 32;   // packed digit vectors, linear count, value
    localparam int STEP_W  = 16;
    localparam int PROD_W  = 33;   // product of bases, up to 2^32
    localparam int ACT_W   = 4;
    localparam int ADDR_W  = 3;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 4'd8;
    localparam logic [FIELD_W-1:0] BASES_RESET  = 32'h1111_1111;

    // command codes
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    // register select (address bit 2)
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_BASES  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_STEPS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
    } t_odo_ctrl;

    typedef struct packed {
        logic [ACT_W-1:0]   active;
        logic [FIELD_W-1:0] bases;
        logic               wr;
    } t_cfg;

endpackage

FILE: rtl/core/mixed_radix_counter.sv
// ----------------------------------------------------------------------------
// mixed_radix_counter
// Mixed-radix odometer counter with clear, advance and convert commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: i_cmd,
//   i_step_count, i_query_digits. Output channel (o_out_valid / i_out_stall)
//   returns exactly one result item per input item, held in an output
//   register until taken.
//   Each item first runs the digit-serial weighting unit, one digit per
//   cycle over the n active digits (product of bases, and the converted
//   value for a convert). An advance then steps the odometer once per cycle,
//   step_count times. The done state then loads the output register;
//   the next item is taken in the cycle after the result is registered.
//   o_in_stall is high while an item is in work. A stalled result stays in
//   the output register; a finished item waits in the done state until the
//   register frees up.
//   Reset (synchronous, active low): counter and linear count zero,
//   8 active digits, every base 2, no result pending.
//   Configuration writes (APB-style, pready tied high) are expected while
//   idle; writing either register clears the count.
// ----------------------------------------------------------------------------
module mixed_radix_counter
    import mrc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [STEP_W-1:0]  i_step_count,
    input  logic [FIELD_W-1:0] i_query_digits,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_count_digits,
    output logic [FIELD_W-1:0] o_linear_count,
    output logic [FIELD_W-1:0] o_converted_value,
    output logic [PROD_W-1:0]  o_total_states,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [FIELD_W-1:0] pwdata,
    output logic [FIELD_W-1:0] prdata,
    output logic               pready
);

    localparam int NW    = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W = (NW > ACT_W) ? NW : ACT_W;

    t_cfg               w_cfg;
    t_odo_ctrl          w_ctrl;
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_cmd;
    logic [1:0]         n_cmd;
    logic [NW-1:0]      r_left;        // digits still to weigh
    logic [NW-1:0]      n_left;
    logic [STEP_W-1:0]  r_steps;       // increments still to do
    logic [STEP_W-1:0]  n_steps;
    logic [NW-1:0]      w_ndig;
    logic [CMP_W-1:0]   w_act;
    logic               w_accept;
    logic               w_conv_load;
    logic               w_conv_run;
    logic               w_out_load;
    logic               r_out_valid;
    logic [FIELD_W-1:0] w_sum;
    logic [PROD_W-1:0]  w_product;
    logic [FIELD_W-1:0] w_count;
    logic [FIELD_W-1:0] w_linear;
    logic [FIELD_W-1:0] r_count_digits;
    logic [FIELD_W-1:0] r_linear_count;
    logic [FIELD_W-1:0] r_converted_value;
    logic [PROD_W-1:0]  r_total_states;

    // active digit count, clamped to 1..MAX_DIGITS
    assign w_act = CMP_W'(w_cfg.active);
    always_comb begin
        if (w_act == '0) begin
            w_ndig = NW'(1);
        end else if (w_act > CMP_W'(MAX_DIGITS)) begin
            w_ndig = NW'(MAX_DIGITS);
        end else begin
            w_ndig = w_act[NW-1:0];
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    mrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mrc_conv #(
        .MAX_DIGITS (MAX_DIGITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_conv (
        .i_clk     (i_clk),
        .i_load    (w_conv_load),
        .i_run     (w_conv_run),
        .i_query   (i_query_digits),
        .i_bases   (w_cfg.bases),
        .i_ndig    (w_ndig),
        .o_sum     (w_sum),
        .o_product (w_product)
    );

    mrc_odometer #(
        .MAX_DIGITS (MAX_DIGITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_odo (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_bases        (w_cfg.bases),
        .i_ndig         (w_ndig),
        .o_count_digits (w_count),
        .o_linear_count (w_linear)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_left  <= n_left;
        r_steps <= n_steps;
    end

    // next state and control
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_left      = r_left;
        n_steps     = r_steps;
        w_conv_load = 1'b0;
        w_conv_run  = 1'b0;
        w_out_load  = 1'b0;
        w_ctrl      = '{clear: w_cfg.wr, step: 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state     = ST_DIGITS;
                    n_cmd       = i_cmd;
                    n_left      = w_ndig;
                    n_steps     = i_step_count;
                    w_conv_load = 1'b1;
                    case (i_cmd)
                        CMD_CLEAR: w_ctrl.clear = 1'b1;
                        default:   w_ctrl.clear = w_cfg.wr;
                    endcase
                end
            end
            ST_DIGITS: begin
                w_conv_run = 1'b1;
                n_left     = r_left - NW'(1);
                if (r_left == NW'(1)) begin
                    if (r_cmd == CMD_ADVANCE && r_steps != '0) begin
                        n_state = ST_STEPS;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_STEPS: begin
                w_ctrl.step = 1'b1;
                n_steps     = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_count_digits    <= w_count;
            r_linear_count    <= w_linear;
            r_converted_value <= (r_cmd == CMD_CONVERT) ? w_sum : '0;
            r_total_states    <= w_product;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_count_digits    = r_count_digits;
    assign o_linear_count    = r_linear_count;
    assign o_converted_value = r_converted_value;
    assign o_total_states    = r_total_states;

endmodule

FILE: rtl/core/mrc_regs.sv
// ----------------------------------------------------------------------------
// mrc_regs
// Configuration registers on an APB-style port; any write clears the count.
// ----------------------------------------------------------------------------
module mrc_regs
    import mrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [FIELD_W-1:0] pwdata,
    output logic [FIELD_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [ACT_W-1:0]   r_active;
    logic [FIELD_W-1:0] r_bases;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            r_bases  <= BASES_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_ACTIVE: r_active <= pwdata[ACT_W-1:0];
                REG_BASES:  r_bases  <= pwdata;
                default:    r_bases  <= r_bases;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ACTIVE: prdata = FIELD_W'(r_active);
            REG_BASES:  prdata = r_bases;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.active = r_active;
    assign o_cfg.bases  = r_bases;
    assign o_cfg.wr     = w_wr;

endmodule

FILE: rtl/core/mrc_conv.sv
// ----------------------------------------------------------------------------
// mrc_conv
// Digit-serial weighting unit: one query digit and one base per cycle,
// least significant digit first; yields the converted value and the product.
// ----------------------------------------------------------------------------
module mrc_conv
    import mrc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_run,
    input  logic [FIELD_W-1:0]                i_query,
    input  logic [FIELD_W-1:0]                i_bases,
    input  logic [$clog2(MAX_DIGITS+1)-1:0]   i_ndig,
    output logic [FIELD_W-1:0]                o_sum,
    output logic [PROD_W-1:0]                 o_product
);

    localparam int PW    = MAX_DIGITS * DIGIT_BITS;
    localparam int EXT_W = (PW > FIELD_W) ? PW : FIELD_W;
    localparam int SH_W  = $clog2(PW + 1);

    logic [EXT_W-1:0]           w_qext;
    logic [EXT_W-1:0]           w_bext;
    logic [SH_W-1:0]            w_shamt;
    logic [PW-1:0]              r_q;
    logic [PW-1:0]              r_b;
    logic [PROD_W-1:0]          r_weight;
    logic [FIELD_W-1:0]         r_sum;
    logic [DIGIT_BITS-1:0]      w_qd;
    logic [DIGIT_BITS:0]        w_bd;
    logic [FIELD_W+DIGIT_BITS-1:0] w_term;
    logic [PROD_W+DIGIT_BITS:0]    w_wprod;

    assign w_qext  = EXT_W'(i_query);
    assign w_bext  = EXT_W'(i_bases);
    // left-justify so digit n-1 sits at the top; inactive digits fall off
    assign w_shamt = SH_W'((MAX_DIGITS - int'(i_ndig)) * DIGIT_BITS);

    assign w_qd    = r_q[PW-1 -: DIGIT_BITS];
    assign w_bd    = {1'b0, r_b[PW-1 -: DIGIT_BITS]} + (DIGIT_BITS+1)'(1);
    assign w_term  = r_weight[FIELD_W-1:0] * w_qd;
    assign w_wprod = r_weight * w_bd;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q      <= w_qext[PW-1:0] << w_shamt;
            r_b      <= w_bext[PW-1:0] << w_shamt;
            r_weight <= PROD_W'(1);
            r_sum    <= '0;
        end else if (i_run) begin
            r_q      <= r_q << DIGIT_BITS;
            r_b      <= r_b << DIGIT_BITS;
            r_weight <= w_wprod[PROD_W-1:0];
            r_sum    <= r_sum + w_term[FIELD_W-1:0];
        end
    end

    assign o_sum     = r_sum;
    assign o_product = r_weight;

endmodule

FILE: rtl/core/mrc_odometer.sv
// ----------------------------------------------------------------------------
// mrc_odometer
// Digit store and single-step increment with carry ripple and wrap.
// ----------------------------------------------------------------------------
module mrc_odometer
    import mrc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_odo_ctrl                         i_ctrl,
    input  logic [FIELD_W-1:0]                i_bases,
    input  logic [$clog2(MAX_DIGITS+1)-1:0]   i_ndig,
    output logic [FIELD_W-1:0]                o_count_digits,
    output logic [FIELD_W-1:0]                o_linear_count
);

    localparam int PW    = MAX_DIGITS * DIGIT_BITS;
    localparam int EXT_W = (PW > FIELD_W) ? PW : FIELD_W;

    logic [DIGIT_BITS-1:0] r_digits [MAX_DIGITS];
    logic [DIGIT_BITS-1:0] n_digits [MAX_DIGITS];
    logic [FIELD_W-1:0]    r_linear;
    logic [FIELD_W-1:0]    n_linear;
    logic [MAX_DIGITS:0]   w_tail;     // digit k and all above it at max
    logic [EXT_W-1:0]      w_bext;
    logic [EXT_W-1:0]      w_pack;

    assign w_bext = EXT_W'(i_bases);

    always_comb begin
        w_tail[MAX_DIGITS] = 1'b1;
        for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
            w_tail[k] = (k >= int'(i_ndig)) ||
                        ((r_digits[k] == w_bext[k*DIGIT_BITS +: DIGIT_BITS]) && w_tail[k+1]);
        end

        n_linear = r_linear;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            n_digits[k] = r_digits[k];
        end

        if (i_ctrl.clear) begin
            n_linear = '0;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                n_digits[k] = '0;
            end
        end else if (i_ctrl.step) begin
            // every active digit at max: the whole counter wraps
            n_linear = w_tail[0] ? '0 : r_linear + FIELD_W'(1);
            for (int k = 0; k < MAX_DIGITS; k++) begin
                if (k < int'(i_ndig)) begin
                    if (w_tail[k]) begin
                        n_digits[k] = '0;
                    end else if (w_tail[k+1]) begin
                        n_digits[k] = r_digits[k] + DIGIT_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= '0;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_digits[k] <= '0;
            end
        end else begin
            r_linear <= n_linear;
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_digits[k] <= n_digits[k];
            end
        end
    end

    always_comb begin
        w_pack = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (k < int'(i_ndig)) begin
                w_pack[k*DIGIT_BITS +: DIGIT_BITS] = r_digits[k];
            end
        end
    end

    assign o_count_digits = w_pack[FIELD_W-1:0];
    assign o_linear_count = r_linear;

endmodule

FILE: rtl/core/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks for the mixed-radix odometer counter, bound to the top.
// ----------------------------------------------------------------------------
module mrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_count_digits,
    input logic [31:0] o_linear_count,
    input logic [31:0] o_converted_value,
    input logic [32:0] o_total_states,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a result is not dropped while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            $stable({o_count_digits, o_linear_count, o_converted_value, o_total_states}))
        else $error("result payload changed under stall");

    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // every base is at least one, so the product never reads zero
    a_states_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_total_states != 33'd0))
        else $error("zero total states");

    // base register reads back what was written
    a_bases_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2])
            |=> (!paddr[2] || (prdata == $past(pwdata))))
        else $error("base register readback mismatch");

endmodule

bind mixed_radix_counter mrc_checker u_mrc_checker (.*);
